[src/lrups_pkg.sv]
package lrups_pkg;

    // Number of page frames held in the recency stack.
    localparam int FRAMES = 16;
    // Width of a stored page number.
    localparam int PAGE_BITS = 20;

    // Width of the stream fields.
    localparam int PAGE_ID_W = 20;
    localparam int STATUS_W = 3;
    localparam int OCC_W = 5;

    // Width of the fill count, which must also hold FRAMES itself.
    localparam int COUNT_BITS = $clog2(FRAMES + 1);
    // Width of an index into the row of cells.
    localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT_MOVED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS_INSERT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICTED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVICT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSERT_DROP = 3'd4;

    // Command codes.
    localparam logic CMD_TOUCH = 1'b0;
    localparam logic CMD_EVICT = 1'b1;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [COUNT_BITS-1:0] t_count;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic  touch;
        t_page page;
    } t_cell_ctrl;

endpackage

[src/lru_page_recency_stack.sv]
// LRU page recency stack. Holds up to FRAMES distinct page numbers ordered by
// recency in a row of compare-and-shift cells, cell 0 holding the most recently
// used page and cell count-1 the least recently used one. A touch beat (tuser 0)
// moves the page to the most recent end, inserting it on a miss and dropping the
// oldest page when the stack is full; an evict beat (tuser 1) removes and reports
// the least recently used page. Every input beat yields exactly one output beat.
// To resolve a beat, all cells compare against the page at
// once, a hit flag ripples along the row, and the row shifts at the next edge,
// so one beat is accepted per cycle while the output register is free or being
// drained. After reset the stack is empty and ready at once.
module lru_page_recency_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [19:0] page_id, [23:20] zero
    input  logic [0:0]  s_axis_tuser,  // [0] cmd
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [19:0] out_page, [24:20] occupancy, [31:25] zero
    output logic [2:0]  m_axis_tuser   // [2:0] status
);
    import lrups_pkg::*;

    // Control state.
    t_count r_count;
    t_count n_count;
    logic   r_m_valid;

    // Result payload register.
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;
    logic [PAGE_ID_W-1:0] r_out_page;
    logic [PAGE_ID_W-1:0] n_out_page;
    logic [OCC_W-1:0]     r_occ;

    logic       w_accept;
    t_cell_ctrl w_ctrl;
    t_page      w_entry [FRAMES];
    t_page      w_prev  [FRAMES];
    logic       w_hit   [FRAMES+1];
    logic       w_valid [FRAMES];
    t_count     w_last;
    t_page      w_lru;

    // A new beat is taken whenever the output register is empty or being drained.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_ctrl.touch = w_accept && (s_axis_tuser[0] == CMD_TOUCH);
    assign w_ctrl.page  = PAGE_BITS'(s_axis_tdata[PAGE_ID_W-1:0]);

    // The hit flag enters the row clear at the most recent end.
    assign w_hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            assign w_valid[g] = (r_count > COUNT_BITS'(g));
            if (g == 0) begin : g_head
                assign w_prev[g] = w_ctrl.page;
            end else begin : g_body
                assign w_prev[g] = w_entry[g-1];
            end
            lrups_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_valid     (w_valid[g]),
                .i_prev      (w_prev[g]),
                .i_hit_below (w_hit[g]),
                .o_entry     (w_entry[g]),
                .o_hit_upto  (w_hit[g+1])
            );
        end
    endgenerate

    // The least recently used page sits in the last occupied cell.
    assign w_last = r_count - COUNT_BITS'(1);
    assign w_lru  = w_entry[w_last[IDX_BITS-1:0]];

    always_comb begin
        n_count    = r_count;
        n_status   = ST_HIT_MOVED;
        n_out_page = '0;
        if (s_axis_tuser[0] == CMD_EVICT) begin
            if (r_count == '0) begin
                n_status = ST_EVICT_EMPTY;
            end else begin
                n_status   = ST_EVICTED;
                n_out_page = PAGE_ID_W'(w_lru);
                n_count    = r_count - COUNT_BITS'(1);
            end
        end else if (w_hit[FRAMES]) begin
            n_status = ST_HIT_MOVED;
        end else if (r_count == COUNT_BITS'(FRAMES)) begin
            // The oldest page falls off the end of the row as the new one enters.
            n_status   = ST_INSERT_DROP;
            n_out_page = PAGE_ID_W'(w_lru);
        end else begin
            n_status = ST_MISS_INSERT;
            n_count  = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_out_page <= n_out_page;
            r_occ      <= OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_occ, r_out_page};
    assign m_axis_tuser  = r_status;

endmodule

[src/lrups_cell.sv]
module lrups_cell (
    input  logic                i_clk,
    input  lrups_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  lrups_pkg::t_page    i_prev,
    input  logic                i_hit_below,
    output lrups_pkg::t_page    o_entry,
    output logic                o_hit_upto
);
    import lrups_pkg::*;

    t_page r_entry;
    logic  w_match;

    // This cell holds the referenced page.
    assign w_match    = i_valid && (r_entry == i_ctrl.page);
    assign o_hit_upto = i_hit_below | w_match;
    assign o_entry    = r_entry;

    // On a touch every cell up to and including the hit (or all cells on a
    // miss) takes the entry of its more recent neighbor; cells past the hit hold.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.touch && !i_hit_below) begin
            r_entry <= i_prev;
        end
    end

endmodule

[sim/lru_recency_checker.sv]
module lru_recency_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [23:0] i_in_tdata,   // [19:0] page_id, [23:20] zero
    input  logic [0:0]  i_in_tuser,   // [0] cmd
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [31:0] i_out_tdata,  // [19:0] out_page, [24:20] occupancy, [31:25] zero
    input  logic [2:0]  i_out_tuser,  // [2:0] status
    output int          o_error_count,
    output int          o_pending
);
    import lrups_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [PAGE_ID_W-1:0] out_page;
        logic [OCC_W-1:0]     occupancy;
    } t_lru_result;

    // Front of the queue is the least recently used page.
    t_page       resident_pages[$];
    t_lru_result expected_results[$];
    int          error_count = 0;

    assign o_error_count = error_count;

    // Applies one reference or eviction to the resident set and returns the result.
    function automatic t_lru_result update_recency(input logic cmd, input t_page page);
        t_lru_result res;
        int          hit_pos;
        res.out_page = '0;
        hit_pos = -1;
        if (cmd == CMD_EVICT) begin
            if (resident_pages.size() == 0) begin
                res.status = ST_EVICT_EMPTY;
            end else begin
                res.out_page = PAGE_ID_W'(resident_pages.pop_front());
                res.status = ST_EVICTED;
            end
        end else begin
            foreach (resident_pages[i]) begin
                if (hit_pos < 0 && resident_pages[i] == page) begin
                    hit_pos = i;
                end
            end
            if (hit_pos >= 0) begin
                resident_pages.delete(hit_pos);
                res.status = ST_HIT_MOVED;
            end else if (resident_pages.size() >= FRAMES) begin
                res.out_page = PAGE_ID_W'(resident_pages.pop_front());
                res.status = ST_INSERT_DROP;
            end else begin
                res.status = ST_MISS_INSERT;
            end
            resident_pages.push_back(page);
        end
        res.occupancy = OCC_W'(resident_pages.size());
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_lru_result want;
        if (!i_rst_n) begin
            resident_pages.delete();
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                expected_results.push_back(
                    update_recency(i_in_tuser[0], i_in_tdata[PAGE_BITS-1:0]));
            end
            if (i_out_tvalid && i_out_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: status %0d, out_page %0h",
                           i_out_tuser, i_out_tdata[19:0]);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_out_tuser);
                        error_count++;
                    end
                    if (i_out_tdata[19:0] !== want.out_page) begin
                        $error("out_page mismatch: expected %0h, actual %0h",
                               want.out_page, i_out_tdata[19:0]);
                        error_count++;
                    end
                    if (i_out_tdata[24:20] !== want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, i_out_tdata[24:20]);
                        error_count++;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

[sim/testbench.sv]
module testbench;
    import lrups_pkg::*;

    localparam int ITEM_COUNT   = 1300;
    localparam int POOL_SIZE    = 24;
    // Generous bound for the watchdog on the whole run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    // Result-side hold-off, counted by the sink itself while the source keeps offering.
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 200;
    // Cycles in which the sink never stalls.
    localparam int SINK_QUIET_FIRST = 1100;
    localparam int SINK_QUIET_LAST  = 1400;
    // Random items around which the source never idles, and the item where it
    // waits until every outstanding result has come back.
    localparam int SRC_QUIET_FIRST = 700;
    localparam int SRC_QUIET_LAST  = 950;
    localparam int PAUSE_ITEM      = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    int          error_count;
    int          pending;
    int          cycle_count = 0;
    t_page       page_pool[POOL_SIZE];

    lru_page_recency_stack uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    lru_recency_checker recency_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_in_tuser    (s_tuser),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .i_out_tuser   (m_tuser),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result sink. Stalls at random, except for one quiet window, and once holds
    // off long enough for the block to fill its output and stall its input.
    initial begin : result_sink
        int sink_cycle;
        sink_cycle = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            sink_cycle++;
            if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_CYCLES) begin
                m_tready <= 1'b0;
            end else if (sink_cycle >= SINK_QUIET_FIRST && sink_cycle < SINK_QUIET_LAST) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. The valid stays
    // high so that a following beat can go out back to back.
    task automatic send_beat(input logic cmd, input t_page page);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= 24'(page);
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Mostly pages from a small pool, so that hits and full-stack drops are
    // common; the rest are arbitrary page numbers that exercise every bit.
    function automatic t_page pick_page(input int span);
        if ($urandom_range(0, 99) < 80) begin
            return page_pool[$urandom_range(0, span - 1)];
        end
        return t_page'($urandom());
    endfunction

    initial begin : stimulus
        int   evict_pct;
        int   pool_span;
        int   phase;
        logic cmd;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_TOUCH;
        foreach (page_pool[i]) begin
            page_pool[i] = t_page'($urandom());
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An evict on the empty stack comes first, with an all-ones
        // page number that the block must ignore.
        send_beat(CMD_EVICT, '1);
        // Extreme page numbers, then a hit that moves page zero to the young end.
        send_beat(CMD_TOUCH, '0);
        send_beat(CMD_TOUCH, '1);
        send_beat(CMD_TOUCH, '0);
        // Fill every frame with distinct pages.
        for (int i = 0; i < FRAMES - 2; i++) begin
            send_beat(CMD_TOUCH, t_page'(20'h5A5A0 + i));
        end
        // A miss on the full stack drops the oldest page, here the all-ones one.
        send_beat(CMD_TOUCH, 20'h12345);
        // A hit in the middle of a full stack, then another drop.
        send_beat(CMD_TOUCH, 20'h5A5A3);
        send_beat(CMD_TOUCH, '1);
        // Plain evictions of the least recently used pages.
        send_beat(CMD_EVICT, '0);
        send_beat(CMD_EVICT, 20'hA5A5A);

        // Random part. The eviction share changes every hundred beats so that the
        // stack swings between full and empty; the pool span changes how often
        // touches hit.
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % 100 == 0) begin
                phase = (n / 100) % 8;
                case (phase)
                    0: begin evict_pct = 5;  end
                    1: begin evict_pct = 30; end
                    2: begin evict_pct = 3;  end
                    3: begin evict_pct = 80; end
                    4: begin evict_pct = 15; end
                    5: begin evict_pct = 55; end
                    6: begin evict_pct = 8;  end
                    default: begin evict_pct = 90; end
                endcase
                pool_span = ((n / 100) % 3 == 1) ? 10 : POOL_SIZE;
            end
            if (n == PAUSE_ITEM) begin
                // Let the block run completely dry before going on.
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) begin
                    @(posedge clk);
                end
            end else if ((n < SRC_QUIET_FIRST || n >= SRC_QUIET_LAST)
                         && $urandom_range(0, 99) < 7) begin
                idle_gap(1);
            end
            cmd = ($urandom_range(0, 99) < evict_pct) ? CMD_EVICT : CMD_TOUCH;
            send_beat(cmd, pick_page(pool_span));
        end
        s_tvalid <= 1'b0;

        // The pending count is registered, so it is read from the next edge on.
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        // The drain wait lets any stray result beat still be seen.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
